/* rtl/tstg_pkg.sv */
// Shared types and constants for the timed square tone generator.
// No dependencies; every other file in rtl/ imports this package.
package tstg_pkg;

  // Dividend width of the compare-top divide (timer clock up to 65535 Hz)
  localparam int unsigned DVD_W = 16;
  localparam int unsigned FREQ_W = 15;
  localparam int unsigned DUR_W = 12;
  localparam int unsigned TOP_W = 8;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned TIMER_CLOCK_HZ_DEF = 31250;

  localparam logic [FREQ_W-1:0] MIN_FREQ_RST = FREQ_W'(123);
  localparam logic [FREQ_W-1:0] MAX_FREQ_RST = FREQ_W'(5000);
  localparam logic [DUR_W-1:0]  MAX_DUR_RST  = DUR_W'(2000);

  localparam logic [TOP_W-1:0] TOP_SAT     = '1;
  localparam logic [DUR_W-1:0] ELAPSED_SAT = '1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_FREQ = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_FREQ = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DUR  = 2'd2;

  typedef struct packed {
    logic [FREQ_W-1:0] min_freq;
    logic [FREQ_W-1:0] max_freq;
    logic [DUR_W-1:0]  max_dur;
  } tstg_cfg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_OUT
  } tstg_state_e;

endpackage

/* rtl/tstg_div.sv */
// Restoring divider: constant timer clock divided by the clamped frequency.
// One quotient bit per cycle through a single compare/subtract unit. Uses tstg_pkg.
module tstg_div import tstg_pkg::*; #(
  parameter int unsigned TIMER_CLOCK_HZ = TIMER_CLOCK_HZ_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [FREQ_W-1:0] divisor_i,
  output logic              done_o,
  output logic [DVD_W-1:0]  quotient_o
);

  localparam int unsigned CNT_W = $clog2(DVD_W);
  localparam logic [DVD_W-1:0] DIVIDEND = DVD_W'(TIMER_CLOCK_HZ);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DVD_W - 1);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [FREQ_W-1:0] rem_q, rem_d;
  logic [FREQ_W-1:0] dsr_q, dsr_d;
  logic [DVD_W-1:0]  dvd_q, dvd_d;
  logic [DVD_W-1:0]  quo_q, quo_d;
  logic [FREQ_W:0]   trial;
  logic              fits;

  // Remainder stays below the divisor, so one extra bit holds the trial value
  assign trial = {rem_q, dvd_q[DVD_W-1]};
  assign fits  = trial >= {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    dvd_d  = dvd_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      dsr_d  = divisor_i;
      dvd_d  = DIVIDEND;
      quo_d  = '0;
    end else if (busy_q) begin
      rem_d = fits ? FREQ_W'(trial - {1'b0, dsr_q}) : trial[FREQ_W-1:0];
      quo_d = {quo_q[DVD_W-2:0], fits};
      dvd_d = {dvd_q[DVD_W-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsr_q <= dsr_d;
    dvd_q <= dvd_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

/* rtl/tstg_core.sv */
// Tone sequencer: request handshake, clamping, tone/timer state and result register.
// Uses tstg_pkg and drives one tstg_div for the compare-top divide.
module tstg_core import tstg_pkg::*; #(
  parameter int unsigned TIMER_CLOCK_HZ = TIMER_CLOCK_HZ_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tstg_cfg_t          cfg_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               req_type_i,
  input  logic signed [15:0] frequency_hz_i,
  input  logic signed [15:0] duration_ms_i,
  input  logic               timer_pulse_i,
  input  logic               ms_pulse_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               buzzer_level_o,
  output logic               tone_active_o,
  output logic [TOP_W-1:0]   compare_top_o
);

  tstg_state_e state_q, state_d;

  logic [TOP_W-1:0] cnt_q, cnt_d;
  logic [TOP_W-1:0] top_q, top_d;
  logic [DUR_W-1:0] elapsed_q, elapsed_d;
  logic [DUR_W-1:0] length_q, length_d;
  logic             active_q, active_d;
  logic             level_q, level_d;

  logic             out_valid_q, out_valid_d;
  logic             out_level_q;
  logic             out_active_q;
  logic [TOP_W-1:0] out_top_q;

  logic              accept;
  logic              load_out;
  logic              div_start;
  logic              div_done;
  logic [DVD_W-1:0]  quotient;

  logic signed [15:0] max_freq_s, min_freq_s, max_dur_s;
  logic [FREQ_W-1:0]  freq_clamped;
  logic [DUR_W-1:0]   dur_clamped;
  logic               dur_pos;
  logic               is_start;
  logic [DUR_W-1:0]   elapsed_inc;
  logic               match;

  assign max_freq_s = {1'b0, cfg_i.max_freq};
  assign min_freq_s = {1'b0, cfg_i.min_freq};
  assign max_dur_s  = {{(16-DUR_W){1'b0}}, cfg_i.max_dur};

  // Test the maximum first, then the minimum
  always_comb begin
    if (frequency_hz_i > max_freq_s) begin
      freq_clamped = cfg_i.max_freq;
    end else if (frequency_hz_i < min_freq_s) begin
      freq_clamped = cfg_i.min_freq;
    end else begin
      freq_clamped = frequency_hz_i[FREQ_W-1:0];
    end
  end

  assign dur_pos     = duration_ms_i > 16'sd0;
  assign dur_clamped = (duration_ms_i > max_dur_s) ? cfg_i.max_dur
                                                   : duration_ms_i[DUR_W-1:0];
  assign is_start    = !req_type_i && dur_pos;

  assign elapsed_inc = (ms_pulse_i && elapsed_q != ELAPSED_SAT) ? elapsed_q + 1'b1
                                                                 : elapsed_q;
  assign match       = cnt_q == top_q;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (is_start && freq_clamped != '0) begin
            state_d = ST_DIV;
          end else begin
            state_d = ST_OUT;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_stall_o = 1'b1;
    accept     = 1'b0;
    div_start  = 1'b0;
    load_out   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        accept     = in_valid_i;
        div_start  = in_valid_i && is_start && freq_clamped != '0;
      end
      ST_DIV: ;
      ST_OUT: load_out = !out_valid_q || !out_stall_i;
      default: ;
    endcase
  end

  // Tone and timer state
  always_comb begin
    cnt_d     = cnt_q;
    top_d     = top_q;
    elapsed_d = elapsed_q;
    length_d  = length_q;
    active_d  = active_q;
    level_d   = level_q;
    if (accept && req_type_i) begin
      elapsed_d = elapsed_inc;
      if (timer_pulse_i) begin
        if (match) begin
          cnt_d = '0;
          if (active_q) begin
            if (elapsed_inc <= length_q) begin
              level_d = !level_q;
            end else begin
              level_d  = 1'b0;
              active_d = 1'b0;
            end
          end
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
    end else if (accept && is_start) begin
      length_d  = dur_clamped;
      cnt_d     = '0;
      elapsed_d = '0;
      active_d  = 1'b1;
      // A clamped frequency of zero saturates the top without dividing
      if (freq_clamped == '0) begin
        top_d = TOP_SAT;
      end
    end
    if (div_done) begin
      top_d = (quotient[DVD_W-1:TOP_W] != '0) ? TOP_SAT : quotient[TOP_W-1:0];
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      top_q       <= '0;
      elapsed_q   <= '0;
      length_q    <= '0;
      active_q    <= 1'b0;
      level_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      top_q       <= top_d;
      elapsed_q   <= elapsed_d;
      length_q    <= length_d;
      active_q    <= active_d;
      level_q     <= level_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload: hold until the next load
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_level_q  <= level_q;
      out_active_q <= active_q;
      out_top_q    <= top_q;
    end
  end

  tstg_div #(
    .TIMER_CLOCK_HZ(TIMER_CLOCK_HZ)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .divisor_i (freq_clamped),
    .done_o    (div_done),
    .quotient_o(quotient)
  );

  assign out_valid_o    = out_valid_q;
  assign buzzer_level_o = out_level_q;
  assign tone_active_o  = out_active_q;
  assign compare_top_o  = out_top_q;

endmodule

/* rtl/timed_square_tone_generator.sv */
// Timed square tone generator: a tick request, an ignored start or a start whose
// clamped frequency is zero moves from acceptance to the output state and its result
// register; any other start first waits in the divide state for the divider. One
// request in flight: a new request is taken only after the last result is loaded.
// Asynchronous active-low reset clears the configuration to its defaults and the
// tone state to idle, level low. Depends on tstg_pkg, tstg_core.
module timed_square_tone_generator import tstg_pkg::*; #(
  parameter int unsigned TIMER_CLOCK_HZ = TIMER_CLOCK_HZ_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [FREQ_W-1:0]    cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 req_type_i,
  input  logic signed [15:0]   frequency_hz_i,
  input  logic signed [15:0]   duration_ms_i,
  input  logic                 timer_pulse_i,
  input  logic                 ms_pulse_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 buzzer_level_o,
  output logic                 tone_active_o,
  output logic [TOP_W-1:0]     compare_top_o
);

  tstg_cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_MIN_FREQ: cfg_d.min_freq = cfg_data_i;
        CFG_MAX_FREQ: cfg_d.max_freq = cfg_data_i;
        CFG_MAX_DUR:  cfg_d.max_dur  = cfg_data_i[DUR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_freq <= MIN_FREQ_RST;
      cfg_q.max_freq <= MAX_FREQ_RST;
      cfg_q.max_dur  <= MAX_DUR_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  tstg_core #(
    .TIMER_CLOCK_HZ(TIMER_CLOCK_HZ)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .req_type_i    (req_type_i),
    .frequency_hz_i(frequency_hz_i),
    .duration_ms_i (duration_ms_i),
    .timer_pulse_i (timer_pulse_i),
    .ms_pulse_i    (ms_pulse_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .buzzer_level_o(buzzer_level_o),
    .tone_active_o (tone_active_o),
    .compare_top_o (compare_top_o)
  );

  // Busy right after taking a request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after a request was taken");

  // A new result only comes out of a busy cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without a request in progress");

  // The buzzer is high only while a tone plays
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !tone_active_o) |-> !buzzer_level_o)
    else $error("buzzer high with no active tone");

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// Self-checking bench for timed_square_tone_generator: start and tick requests
// are predicted in-bench and every result is compared in order.
// Depends on tstg_pkg and the RTL top level.
module tb;
  import tstg_pkg::*;

  typedef enum bit {
    REQ_START = 1'b0,
    REQ_TICK  = 1'b1
  } req_kind_e;

  typedef struct {
    req_kind_e          kind;
    logic signed [15:0] freq;
    logic signed [15:0] dur;
    bit                 timer;
    bit                 ms;
  } tone_req_t;

  typedef struct {
    bit               level;
    bit               active;
    logic [TOP_W-1:0] top;
  } tone_res_t;

  localparam int QUIET_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 40;
  localparam int REPORT_MAX   = 10;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = CFG_MIN_FREQ;
  logic [FREQ_W-1:0]    cfg_data_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic                 req_type_i = 1'b0;
  logic signed [15:0]   frequency_hz_i = '0;
  logic signed [15:0]   duration_ms_i = '0;
  logic                 timer_pulse_i = 1'b0;
  logic                 ms_pulse_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic                 buzzer_level_o;
  logic                 tone_active_o;
  logic [TOP_W-1:0]     compare_top_o;

  timed_square_tone_generator dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .req_type_i     (req_type_i),
    .frequency_hz_i (frequency_hz_i),
    .duration_ms_i  (duration_ms_i),
    .timer_pulse_i  (timer_pulse_i),
    .ms_pulse_i     (ms_pulse_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .buzzer_level_o (buzzer_level_o),
    .tone_active_o  (tone_active_o),
    .compare_top_o  (compare_top_o)
  );

  always #1 clk_i = ~clk_i;

  // Predicted tone state and limits
  logic [TOP_W-1:0]  cnt_m;
  logic [TOP_W-1:0]  top_m;
  logic [DUR_W-1:0]  elapsed_m;
  logic [DUR_W-1:0]  len_m;
  bit                on_m;
  bit                level_m;
  logic [FREQ_W-1:0] min_f_m;
  logic [FREQ_W-1:0] max_f_m;
  logic [DUR_W-1:0]  max_d_m;

  tone_req_t pending_q[$];
  tone_res_t tone_due_q[$];
  tone_req_t cur_req;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_req = 0;
  int hold_done = 0;
  int hold_left = 0;
  int quiet = 0;
  int n_accepted = 0;
  int n_starts = 0;
  int n_checked = 0;
  int n_cfg = 0;
  int n_errors = 0;

  // Clamp against the maximum first, then the minimum, then divide
  function automatic logic [TOP_W-1:0] clamped_top(logic signed [15:0] req);
    int f;
    int q;
    f = int'(req);
    if (f > int'(max_f_m)) f = int'(max_f_m);
    else if (f < int'(min_f_m)) f = int'(min_f_m);
    if (f <= 0) return TOP_SAT;
    q = int'(TIMER_CLOCK_HZ_DEF) / f;
    return (q > int'(TOP_SAT)) ? TOP_SAT : TOP_W'(q);
  endfunction

  function automatic tone_res_t step_tone(tone_req_t r);
    tone_res_t res;
    int d;
    if (r.kind == REQ_START) begin
      d = int'(r.dur);
      if (d > 0) begin
        if (d > int'(max_d_m)) d = int'(max_d_m);
        len_m = DUR_W'(d);
        top_m = clamped_top(r.freq);
        cnt_m = '0;
        elapsed_m = '0;
        on_m = 1'b1;
      end
    end else begin
      // millisecond first, then the timer clock
      if (r.ms && elapsed_m != ELAPSED_SAT) elapsed_m = elapsed_m + 1'b1;
      if (r.timer) begin
        if (cnt_m == top_m) begin
          cnt_m = '0;
          if (on_m) begin
            if (elapsed_m <= len_m) begin
              level_m = !level_m;
            end else begin
              level_m = 1'b0;
              on_m = 1'b0;
            end
          end
        end else begin
          cnt_m = cnt_m + 1'b1;
        end
      end
    end
    res.level = level_m;
    res.active = on_m;
    res.top = top_m;
    return res;
  endfunction

  // Request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        tone_due_q.push_back(step_tone(cur_req));
        n_accepted++;
        if (cur_req.kind == REQ_START) n_starts++;
      end
      // hold a stalled request, otherwise offer the next one or idle
      if (!in_valid_i || !in_stall_o) begin
        if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_req = pending_q.pop_front();
          in_valid_i <= 1'b1;
          req_type_i <= cur_req.kind;
          frequency_hz_i <= cur_req.freq;
          duration_ms_i <= cur_req.dur;
          timer_pulse_i <= cur_req.timer;
          ms_pulse_i <= cur_req.ms;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver stall
  always @(posedge clk_i or negedge rst_ni) begin : result_side
    tone_res_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (tone_due_q.size() == 0) begin
          n_errors++;
          if (n_errors <= REPORT_MAX)
            $display("unexpected result: level %0b active %0b top %0d",
                     buzzer_level_o, tone_active_o, compare_top_o);
        end else begin
          want = tone_due_q.pop_front();
          if (buzzer_level_o !== want.level || tone_active_o !== want.active ||
              compare_top_o !== want.top) begin
            n_errors++;
            if (n_errors <= REPORT_MAX)
              $display("result %0d: expected level %0b active %0b top %0d, got %0b %0b %0d",
                       n_checked, want.level, want.active, want.top,
                       buzzer_level_o, tone_active_o, compare_top_o);
          end
          n_checked++;
        end
      end
      if (hold_left == 0 && hold_done != hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_done++;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet <= 0;
    end else if (quiet == QUIET_LIMIT) begin
      $display("no request moved for %0d cycles", QUIET_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic wait_idle();
    while (pending_q.size() != 0 || in_valid_i || tone_due_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [FREQ_W-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_MIN_FREQ: min_f_m = val;
      CFG_MAX_FREQ: max_f_m = val;
      CFG_MAX_DUR:  max_d_m = DUR_W'(val);
      default: ;
    endcase
    n_cfg++;
  endtask

  task automatic set_limits(int lo, int hi, int cap);
    wait_idle();
    write_reg(CFG_MIN_FREQ, FREQ_W'(lo));
    write_reg(CFG_MAX_FREQ, FREQ_W'(hi));
    write_reg(CFG_MAX_DUR, FREQ_W'(cap));
  endtask

  task automatic queue_req(req_kind_e k, int f, int d, bit tp, bit mp);
    tone_req_t r;
    r.kind = k;
    r.freq = 16'(f);
    r.dur = 16'(d);
    r.timer = tp;
    r.ms = mp;
    pending_q.push_back(r);
  endtask

  // Mostly a start followed by a burst of ticks, some raw noise in between
  task automatic random_burst(int n_items);
    int made;
    int n_ticks;
    int f;
    int d;
    made = 0;
    while (made < n_items) begin
      if ($urandom_range(9) < 2) begin
        queue_req(req_kind_e'($urandom_range(1)), $urandom, $urandom,
                  1'($urandom_range(1)), 1'($urandom_range(1)));
        made++;
      end else begin
        f = ($urandom_range(3) == 0) ? int'($urandom_range(65535)) - 32768
                                     : int'($urandom_range(32767));
        d = ($urandom_range(3) == 0) ? int'($urandom_range(32767, 1))
                                     : int'($urandom_range(12, 1));
        queue_req(REQ_START, f, d, 1'($urandom_range(1)), 1'($urandom_range(1)));
        n_ticks = $urandom_range(40, 4);
        repeat (n_ticks)
          queue_req(REQ_TICK, $urandom, $urandom, $urandom_range(3) != 0,
                    $urandom_range(3) == 0);
        made += n_ticks + 1;
      end
    end
  endtask

  initial begin : stimulus
    int lo;
    int hi;
    int cap;
    cnt_m = '0;
    top_m = '0;
    elapsed_m = '0;
    len_m = '0;
    on_m = 1'b0;
    level_m = 1'b0;
    min_f_m = MIN_FREQ_RST;
    max_f_m = MAX_FREQ_RST;
    max_d_m = MAX_DUR_RST;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset limits: idle timer, ignored starts, pulses on a start, clamps
    queue_req(REQ_TICK, 0, 0, 1'b1, 1'b1);
    queue_req(REQ_START, 1000, 0, 1'b1, 1'b1);
    queue_req(REQ_START, 1000, -32768, 1'b0, 1'b0);
    queue_req(REQ_START, 32767, 32767, 1'b1, 1'b1);
    queue_req(REQ_START, -32768, 1, 1'b0, 1'b0);

    // Widest limits: saturated top, then a top of zero toggling on every pulse
    set_limits(1, 32767, 4095);
    queue_req(REQ_START, 1, 100, 1'b0, 1'b0);
    queue_req(REQ_START, 32767, 4095, 1'b0, 1'b0);
    repeat (3) queue_req(REQ_TICK, -1, -1, 1'b1, 1'b1);

    // Both clamps at zero leave a zero frequency
    set_limits(0, 0, 0);
    queue_req(REQ_START, 0, 5, 1'b0, 1'b0);
    queue_req(REQ_START, -5, 5, 1'b0, 1'b0);

    // Minimum above maximum
    set_limits(300, 100, 50);
    queue_req(REQ_START, 50, 1, 1'b0, 1'b0);
    queue_req(REQ_START, 200, 1, 1'b0, 1'b0);

    // Zero duration cap: the tone stops on the first match after a millisecond
    set_limits(31250, 31250, 0);
    queue_req(REQ_START, 20000, 7, 1'b0, 1'b0);
    queue_req(REQ_TICK, 0, 0, 1'b1, 1'b0);
    queue_req(REQ_TICK, 0, 0, 1'b1, 1'b0);
    queue_req(REQ_TICK, 0, 0, 1'b1, 1'b1);
    queue_req(REQ_TICK, 0, 0, 1'b1, 1'b0);

    // Longest tone: it keeps playing through a run of milliseconds until restarted
    set_limits(31250, 31250, 4095);
    queue_req(REQ_START, 31250, 32767, 1'b0, 1'b0);
    repeat (60) queue_req(REQ_TICK, $urandom, $urandom, 1'($urandom_range(1)), 1'b1);
    queue_req(REQ_START, 31250, 3, 1'b0, 1'b0);
    repeat (8) queue_req(REQ_TICK, $urandom, $urandom, 1'b1, 1'b1);

    for (int ph = 0; ph < 6; ph++) begin
      if ($urandom_range(2) == 0) begin
        lo = $urandom_range(32767);
        hi = $urandom_range(32767);
        cap = $urandom_range(4095);
      end else begin
        lo = $urandom_range(1500, 1);
        hi = $urandom_range(31250, 1000);
        cap = $urandom_range(4095, 1);
      end
      set_limits(lo, hi, cap);
      send_idle_pct = (ph < 2) ? 17 : (ph < 4) ? 64 : 0;
      recv_idle_pct = (ph < 2) ? 64 : (ph < 4) ? 17 : 0;
      random_burst(85);
      // stall results for a long stretch while requests keep coming
      if (ph == 0) hold_req++;
      // drain completely before the second half
      if (ph == 3) wait_idle();
      random_burst(85);
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("%0d requests (%0d starts) and %0d results checked, %0d register writes",
             n_accepted, n_starts, n_checked, n_cfg);
    $display("clamp extremes, ignored starts, zero and saturated tops, long tone, back-pressure");
    if (n_errors == 0 && tone_due_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* timed_square_tone_generator.f */
rtl/tstg_pkg.sv
rtl/tstg_div.sv
rtl/tstg_core.sv
rtl/timed_square_tone_generator.sv
tb/tb.sv
